@@ sv/odt_pkg.sv @@
// Shared types and constants of the one-shot delay timer.
package odt_pkg;

    localparam int TICKS_PER_CYCLE = 256;
    localparam int TICK_W          = $clog2(TICKS_PER_CYCLE);

    localparam int DUR_W  = 16;
    localparam int CYC_W  = 12;
    localparam int CPS_W  = 8;
    localparam int OVF_W  = 16;
    localparam int PROD_W = DUR_W + CPS_W;

    // duration * 10 needs four more bits than the duration itself
    localparam int T_W       = DUR_W + 4;
    localparam int Q_W       = T_W + TICK_W;
    localparam int DIV_CNT_W = $clog2(Q_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TENTHS_MS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_SECOND = CFG_IDX_W'(1);

    localparam logic [CYC_W-1:0] CYCLE_TENTHS_MS_RST   = CYC_W'(163);
    localparam logic [CPS_W-1:0] CYCLES_PER_SECOND_RST = CPS_W'(61);

    typedef enum logic [1:0] {
        OP_START_MS = 2'd0,
        OP_START_S  = 2'd1,
        OP_STOP     = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_OVF  = 2'd1,
        PH_CMP  = 2'd2
    } phase_t;

    typedef struct packed {
        op_t              op;
        logic [DUR_W-1:0] duration;
    } in_item_t;

    typedef struct packed {
        logic   active;
        logic   expired;
        phase_t phase;
    } out_item_t;

endpackage

@@ sv/one_shot_delay_timer.sv @@
// Top level of the one-shot delay timer: command sequencer, timer state and result register.

// Every request yields exactly one result. Tick, stop and seconds-start requests are
// handled in the cycle they are accepted, so their result is registered in the cycle after.
// A milliseconds start runs duration * 10 * 256 through a restoring divider that produces
// one quotient bit per cycle over its 28-bit dividend; the result is written once the
// divider is done and the output is free, and no further request is taken until then.
// Configuration writes are always accepted and take effect at once; they are meant to be
// made while no request is in progress.
module one_shot_delay_timer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  odt_pkg::in_item_t              s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output odt_pkg::out_item_t             m_payload,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [odt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [odt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import odt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [OVF_W-1:0]  ovf_reg, ovf_next;
    logic [TICK_W-1:0] rtop_reg, rtop_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_payload_reg, m_payload_next;
    logic [CYC_W-1:0]  cyc_tenths_reg;
    logic [CPS_W-1:0]  cps_reg;

    logic              in_acc;
    logic              out_slot;
    logic              expired_v;
    logic              out_write;
    logic [T_W-1:0]    dur_x10;
    logic [CYC_W-1:0]  divisor;
    logic              div_done;
    logic [Q_W-1:0]    div_quo;
    logic [OVF_W-1:0]  ms_cycles;
    logic [PROD_W-1:0] sec_prod;
    logic [OVF_W-1:0]  sec_cycles;

    assign out_slot  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_slot;
    assign in_acc    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign dur_x10 = (T_W'(s_payload.duration) << 3) + (T_W'(s_payload.duration) << 1);
    assign divisor = (cyc_tenths_reg == '0) ? CYC_W'(1) : cyc_tenths_reg;

    odt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_acc && (s_payload.op == OP_START_MS)),
        .dividend ({dur_x10, TICK_W'(0)}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // The low quotient bits are the scaled remainder; the upper ones count whole cycles.
    assign ms_cycles = (|div_quo[Q_W-1:OVF_W+TICK_W]) ? '1 : div_quo[OVF_W+TICK_W-1:TICK_W];

    assign sec_prod   = PROD_W'(s_payload.duration) * PROD_W'(cps_reg);
    assign sec_cycles = (|sec_prod[PROD_W-1:OVF_W]) ? '1 : sec_prod[OVF_W-1:0];

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        ovf_next       = ovf_reg;
        rtop_next      = rtop_reg;
        expired_v      = 1'b0;
        out_write      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_payload.op)
                        OP_START_MS: begin
                            state_next = ST_DIV;
                        end
                        OP_START_S: begin
                            out_write = 1'b1;
                            tick_next = '0;
                            rtop_next = '0;
                            if (sec_cycles != '0) begin
                                ovf_next   = sec_cycles;
                                phase_next = PH_OVF;
                            end else begin
                                ovf_next   = '0;
                                phase_next = PH_IDLE;
                            end
                        end
                        OP_STOP: begin
                            out_write  = 1'b1;
                            tick_next  = '0;
                            ovf_next   = '0;
                            rtop_next  = '0;
                            phase_next = PH_IDLE;
                        end
                        OP_TICK: begin
                            out_write = 1'b1;
                            unique case (phase_reg)
                                PH_OVF: begin
                                    if ({1'b0, tick_reg} + (TICK_W+1)'(1)
                                            >= (TICK_W+1)'(TICKS_PER_CYCLE)) begin
                                        tick_next = '0;
                                        if (ovf_reg > OVF_W'(1)) begin
                                            ovf_next = ovf_reg - OVF_W'(1);
                                        end else begin
                                            ovf_next   = '0;
                                            phase_next = PH_CMP;
                                        end
                                    end else begin
                                        tick_next = tick_reg + TICK_W'(1);
                                    end
                                end
                                PH_CMP: begin
                                    if (tick_reg == rtop_reg) begin
                                        expired_v  = 1'b1;
                                        tick_next  = '0;
                                        ovf_next   = '0;
                                        rtop_next  = '0;
                                        phase_next = PH_IDLE;
                                    end else begin
                                        tick_next = tick_reg + TICK_W'(1);
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_slot) begin
                    out_write  = 1'b1;
                    state_next = ST_IDLE;
                    tick_next  = '0;
                    rtop_next  = div_quo[TICK_W-1:0];
                    if (ms_cycles != '0) begin
                        ovf_next   = ms_cycles;
                        phase_next = PH_OVF;
                    end else begin
                        ovf_next   = '0;
                        phase_next = PH_CMP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (out_write) begin
            m_valid_next           = 1'b1;
            m_payload_next.active  = (phase_next != PH_IDLE);
            m_payload_next.expired = expired_v;
            m_payload_next.phase   = phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            ovf_reg        <= '0;
            rtop_reg       <= '0;
            m_valid_reg    <= 1'b0;
            cyc_tenths_reg <= CYCLE_TENTHS_MS_RST;
            cps_reg        <= CYCLES_PER_SECOND_RST;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            ovf_reg     <= ovf_next;
            rtop_reg    <= rtop_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_CYCLE_TENTHS_MS:   cyc_tenths_reg <= cfg_data[CYC_W-1:0];
                    CFG_CYCLES_PER_SECOND: cps_reg        <= cfg_data[CPS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef ASSERT_OFF
    a_div_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_done) |=> (state_reg == ST_LOAD))
        else $error("divider completion did not move the sequencer to the load step");

    a_ms_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_payload.op == OP_START_MS) |=> (state_reg == ST_DIV && !s_ready))
        else $error("milliseconds start did not hold off further requests");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (tick_reg == '0 && ovf_reg == '0 && rtop_reg == '0))
        else $error("timer state not cleared while idle");

    a_ovf_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OVF) |-> (ovf_reg != '0))
        else $error("overflow phase entered with no cycles left");
`endif

endmodule

@@ sv/odt_div.sv @@
// Iterative restoring divider: one quotient bit per clock cycle.
module odt_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [odt_pkg::Q_W-1:0]   dividend,
    input  logic [odt_pkg::CYC_W-1:0] divisor,
    output logic                      done,
    output logic [odt_pkg::Q_W-1:0]   quotient
);
    import odt_pkg::*;

    logic [CYC_W:0]     rem_reg, rem_next;
    logic [Q_W-1:0]     quo_reg, quo_next;
    logic [CYC_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [CYC_W:0]     rem_sh;
    logic [CYC_W+1:0]   diff;
    logic               fits;

    always_comb begin
        rem_sh = {rem_reg[CYC_W-1:0], quo_reg[Q_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        fits   = !diff[CYC_W+1];

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[CYC_W:0] : rem_sh;
            quo_next = {quo_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
